FILE: rtl/colp_pkg.sv
// Package for the cascaded one-pole lowpass: step codes, control word and microcode ROM.
`timescale 1ns / 1ps
package colp_pkg;

  localparam int SampleW = 16;
  localparam int ValueW  = 24;
  localparam int CoefW   = 16;
  localparam int CountW  = 6;
  localparam int CfgW    = 16;

  // Configuration register indexes.
  localparam logic REG_STAGE_COUNT = 1'b0;
  localparam logic REG_SMOOTHING   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_CHECK = 3'd1,
    ST_MUL   = 3'd2,
    ST_ADD   = 3'd3,
    ST_FIN   = 3'd4
  } step_e;

  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_NO_IN    = 3'd1,
    C_ZERO     = 3'd2,
    C_MORE     = 3'd3,
    C_OUT_BUSY = 3'd4
  } cond_e;

  typedef enum logic {
    RD_FIRST = 1'b0,
    RD_NEXT  = 1'b1
  } rd_sel_e;

  typedef struct packed {
    logic    in_rdy;   // take an item this step
    logic    ld_v;     // load the running value from the sample
    logic    clr_idx;  // restart at stage zero
    logic    rd_en;    // issue a stage memory read
    rd_sel_e rd_sel;
    logic    mul_en;   // register k * (old - v)
    logic    add_en;   // update v, write the stage, advance the index
    logic    out_ld;   // load the output register when it is free
    cond_e   cond;
    step_e   jmp;
    step_e   nxt;
  } ctrl_t;

  function automatic ctrl_t ucode_rom(step_e pc);
    ctrl_t cw;
    cw = '{in_rdy: 1'b0, ld_v: 1'b0, clr_idx: 1'b0, rd_en: 1'b0, rd_sel: RD_FIRST,
           mul_en: 1'b0, add_en: 1'b0, out_ld: 1'b0, cond: C_NEVER,
           jmp: ST_IDLE, nxt: ST_IDLE};
    unique case (pc)
      ST_IDLE: begin
        cw.in_rdy  = 1'b1;
        cw.ld_v    = 1'b1;
        cw.clr_idx = 1'b1;
        cw.rd_en   = 1'b1;
        cw.rd_sel  = RD_FIRST;
        cw.cond    = C_NO_IN;
        cw.jmp     = ST_IDLE;
        cw.nxt     = ST_CHECK;
      end
      ST_CHECK: begin
        cw.cond = C_ZERO;
        cw.jmp  = ST_FIN;
        cw.nxt  = ST_MUL;
      end
      ST_MUL: begin
        cw.mul_en = 1'b1;
        cw.rd_en  = 1'b1;
        cw.rd_sel = RD_NEXT;
        cw.cond   = C_NEVER;
        cw.jmp    = ST_MUL;
        cw.nxt    = ST_ADD;
      end
      ST_ADD: begin
        cw.add_en = 1'b1;
        cw.cond   = C_MORE;
        cw.jmp    = ST_MUL;
        cw.nxt    = ST_FIN;
      end
      ST_FIN: begin
        cw.out_ld = 1'b1;
        cw.cond   = C_OUT_BUSY;
        cw.jmp    = ST_FIN;
        cw.nxt    = ST_IDLE;
      end
      default: begin
        cw.cond = C_NEVER;
        cw.nxt  = ST_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

FILE: rtl/colp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module colp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/cascaded_one_pole_lowpass_top.sv
// Top level of the cascaded one-pole lowpass: microcoded sequencer around one multiplier.
//
// Usage: samples enter on in_valid_i / in_stall_o / sample_in_i and filtered samples
// leave on out_valid_o / out_stall_i / sample_out_o; an item moves at a clock edge with
// valid high and stall low. Every input item gives exactly one output item.
// Each item walks the active stages one at a time through a shared multiplier: one
// step forms k * (old - v) and the next adds it back and writes the stage memory.
// After the idle step accepts an item, a check step skips the stages in bypass, the
// multiply and add steps repeat for each active stage, the final step loads the output
// register, and only back in the idle step is the next item accepted.
// stage_count and smoothing_factor are written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i; the user must write them only while the block is idle, as the block
// itself does not enforce this. Counts above MAX_STAGES act as MAX_STAGES.
// Reset sets stage_count to 1 and k to 0 and clears all stage values at once
// through per-stage valid bits, so no clearing pass is needed.
// A stalled receiver holds the output register; the block still accepts and
// processes one more item, which then waits in the final step until the output
// register is free.
`timescale 1ns / 1ps
module cascaded_one_pole_lowpass_top
  import colp_pkg::*;
#(
  parameter int MAX_STAGES = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [CfgW-1:0]           cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] sample_in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SampleW-1:0] sample_out_o
);

  localparam int AW    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int CW    = $clog2(MAX_STAGES + 1);
  localparam int DiffW = ValueW + 1;
  localparam int ProdW = DiffW + CoefW + 1;
  localparam int StepW = ProdW - CoefW;

  step_e pc_q, pc_d;
  ctrl_t cw;

  logic [CountW-1:0] count_q;
  logic [CoefW-1:0]  coef_q;

  logic [CW-1:0]           idx_q;
  logic [CW-1:0]           idx_nx;
  logic [CW-1:0]           n_eff;
  logic [MAX_STAGES-1:0]   vld_q;
  logic                    rvld_q;
  logic signed [ValueW-1:0] v_q;
  logic signed [ProdW-1:0]  prod_q;
  logic                    out_valid_q;
  logic signed [SampleW-1:0] out_q;

  logic                     in_acc;
  logic                     out_busy;
  logic                     cond_hit;
  logic                     out_ld_eff;
  logic [AW-1:0]            raddr;
  logic [ValueW-1:0]        rdata;
  logic signed [ValueW-1:0] old_val;
  logic signed [DiffW-1:0]  diff;
  logic signed [StepW-1:0]  step_val;
  logic signed [StepW-1:0]  v_sum;
  logic signed [ValueW-1:0] v_new;
  logic signed [ValueW:0]   rnd;
  logic signed [SampleW:0]  rnd_sh;
  logic signed [SampleW-1:0] sat_val;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountW'(1);
      coef_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STAGE_COUNT: count_q <= cfg_wdata_i[CountW-1:0];
        REG_SMOOTHING:   coef_q  <= cfg_wdata_i[CoefW-1:0];
        default: ;
      endcase
    end
  end

  assign n_eff = (int'(count_q) > MAX_STAGES) ? CW'(MAX_STAGES) : CW'(count_q);

  // Control word for the current step.
  always_comb begin
    cw = ucode_rom(pc_q);
  end

  assign in_acc   = cw.in_rdy && in_valid_i;
  assign out_busy = out_valid_q && out_stall_i;
  assign idx_nx   = idx_q + CW'(1);

  always_comb begin
    unique case (cw.cond)
      C_NEVER:    cond_hit = 1'b0;
      C_NO_IN:    cond_hit = !in_valid_i;
      C_ZERO:     cond_hit = (n_eff == '0);
      C_MORE:     cond_hit = (idx_nx < n_eff);
      C_OUT_BUSY: cond_hit = out_busy;
      default:    cond_hit = 1'b0;
    endcase
  end

  // Next step.
  always_comb begin
    pc_d = cond_hit ? cw.jmp : cw.nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign out_ld_eff = cw.out_ld && !out_busy;

  // Stage memory; entries never written since reset read as zero.
  assign raddr = (cw.rd_sel == RD_NEXT) ? idx_nx[AW-1:0] : '0;

  colp_ram #(
    .WIDTH(ValueW),
    .DEPTH(MAX_STAGES)
  ) u_stage_ram (
    .clk_i  (clk_i),
    .we_i   (cw.add_en),
    .waddr_i(idx_q[AW-1:0]),
    .wdata_i(v_new),
    .re_i   (cw.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign old_val = rvld_q ? $signed(rdata) : '0;

  // Datapath: diff and product in one step, the update in the next.
  assign diff     = DiffW'(old_val) - DiffW'(v_q);
  assign step_val = prod_q[ProdW-1:CoefW];
  assign v_sum    = StepW'(v_q) + step_val;
  assign v_new    = v_sum[ValueW-1:0];

  // Round half up, then saturate; only the top end can overflow.
  assign rnd    = (ValueW + 1)'(v_q) + (ValueW + 1)'(128);
  assign rnd_sh = rnd[ValueW:ValueW-SampleW];
  always_comb begin
    if (rnd_sh > (SampleW + 1)'(32767)) begin
      sat_val = SampleW'(32767);
    end else begin
      sat_val = rnd_sh[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      vld_q       <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cw.clr_idx) begin
        idx_q <= '0;
      end else if (cw.add_en) begin
        idx_q <= idx_nx;
      end
      if (cw.add_en) begin
        vld_q[idx_q[AW-1:0]] <= 1'b1;
      end
      if (cw.rd_en) begin
        rvld_q <= vld_q[raddr];
      end
      if (out_ld_eff) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw.ld_v && in_acc) begin
      v_q <= ValueW'(sample_in_i) <<< 8;
    end else if (cw.add_en) begin
      v_q <= v_new;
    end
    if (cw.mul_en) begin
      prod_q <= ProdW'(diff) * $signed({1'b0, coef_q});
    end
    if (out_ld_eff) begin
      out_q <= sat_val;
    end
  end

  assign in_stall_o   = !cw.in_rdy;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  // Stage updates stay inside the active range.
  a_add_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == ST_ADD) |-> (idx_q < n_eff))
    else $error("stage update beyond active stage count");

  // An accepted item always goes to the stage check next.
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (pc_q == ST_CHECK))
    else $error("accepted item did not start processing");

  // The output register is never overwritten while the receiver holds it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == ST_FIN && out_valid_q && out_stall_i) |=> (pc_q == ST_FIN && out_valid_q))
    else $error("pending output lost");

  // A finished item leaves the final step with a valid output.
  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == ST_FIN && !(out_valid_q && out_stall_i)) |=> (out_valid_q && pc_q == ST_IDLE))
    else $error("final step did not load output");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the cascaded one-pole lowpass with an item-level filter predictor.
`timescale 1ns / 1ps
module tb_top
  import colp_pkg::*;
();

  localparam int NUM_STAGES  = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1900;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic                      cfg_idx_i   = REG_STAGE_COUNT;
  logic [CfgW-1:0]           cfg_wdata_i = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic signed [SampleW-1:0] sample_in_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [SampleW-1:0] sample_out_o;

  cascaded_one_pole_lowpass_top #(
    .MAX_STAGES(NUM_STAGES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_out_o(sample_out_o)
  );

  always #10 clk_i = ~clk_i;

  // Mirror of the filter registers and stage state; the stage values are updated as items are accepted.
  logic        [CountW-1:0] cfg_stages = 6'd1;
  logic        [CoefW-1:0]  cfg_k      = '0;
  logic signed [ValueW-1:0] stage_mem [NUM_STAGES];

  logic signed [SampleW-1:0] sample_queue     [$];
  logic signed [SampleW-1:0] expected_samples [$];

  bit no_idle = 1'b0;
  int drv_wait = 0;
  int mon_wait = 0;
  int fail_count = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int bypass_items = 0;
  int full_depth_items = 0;
  int phase_count = 0;
  int cycle_count = 0;

  function automatic logic signed [SampleW-1:0] lowpass_predict(logic signed [SampleW-1:0] s);
    longint acc;
    longint prev;
    longint rounded;
    int     depth;
    depth = (cfg_stages > NUM_STAGES) ? NUM_STAGES : int'(cfg_stages);
    if (depth == 0) return s;
    acc = longint'(s) * 256;
    for (int i = 0; i < depth; i++) begin
      prev = stage_mem[i];
      acc = acc + ((longint'(cfg_k) * (prev - acc)) >>> 16);
      stage_mem[i] = acc[ValueW-1:0];
    end
    rounded = (acc + 128) >>> 8;
    if (rounded > 32767) rounded = 32767;
    if (rounded < -32768) rounded = -32768;
    return rounded[SampleW-1:0];
  endfunction

  // Input driver: one item at a time from the sample queue, with a drawn gap after each.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      sample_in_i <= '0;
      drv_wait    <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_samples.push_back(lowpass_predict(sample_in_i));
        items_accepted++;
        if (cfg_stages == 0) bypass_items++;
        if (cfg_stages >= NUM_STAGES) full_depth_items++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (drv_wait > 0) begin
          drv_wait   <= drv_wait - 1;
          in_valid_i <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          in_valid_i  <= 1'b1;
          sample_in_i <= sample_queue.pop_front();
          drv_wait    <= no_idle ? 0 : $urandom_range(0, 14);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each result and stalls for a drawn number of cycles after it.
  always @(posedge clk_i or negedge rst_ni) begin
    int hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      mon_wait    <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result, expected none, got sample_out %0d",
                   $time, sample_out_o);
          fail_count++;
        end else begin
          if (sample_out_o !== expected_samples[0]) begin
            $display("%0t: sample_out expected %0d, got %0d",
                     $time, expected_samples[0], sample_out_o);
            fail_count++;
          end
          void'(expected_samples.pop_front());
        end
        results_checked++;
        hold = no_idle ? 0 : $urandom_range(0, 14);
        out_stall_i <= (hold > 0);
        mon_wait    <= (hold > 0) ? hold - 1 : 0;
      end else if (mon_wait > 0) begin
        mon_wait    <= mon_wait - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_samples.size());
      $display("cascaded_one_pole_lowpass_top: mismatch");
      $finish;
    end
  end

  // Both registers are written back to back while the block is idle.
  task automatic set_filter(logic [CfgW-1:0] count_word, logic [CfgW-1:0] k_word);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_STAGE_COUNT;
    cfg_wdata_i <= count_word;
    @(posedge clk_i);
    cfg_idx_i   <= REG_SMOOTHING;
    cfg_wdata_i <= k_word;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_stages = count_word[CountW-1:0];
    cfg_k      = k_word;
    phase_count++;
    @(negedge clk_i);
  endtask

  // Sampled on the falling edge so the driver's updates of the rising edge have settled.
  task automatic drain();
    while (sample_queue.size() != 0 || expected_samples.size() != 0 || in_valid_i)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_phase(int n_items);
    logic [CfgW-1:0]           count_word;
    logic [CfgW-1:0]           k_word;
    logic signed [SampleW-1:0] s;
    int                        pick;
    int                        style;
    int                        delta;
    count_word = $urandom;
    pick = $urandom_range(0, 9);
    if (pick < 5) count_word[5:0] = $urandom_range(1, 6);
    else if (pick == 5) count_word[5:0] = 6'd0;
    else if (pick == 6) count_word[5:0] = 6'd32;
    else if (pick == 7) count_word[5:0] = $urandom_range(33, 63);
    else count_word[5:0] = $urandom_range(7, 31);
    pick = $urandom_range(0, 7);
    case (pick)
      0: k_word = 16'h0000;
      1: k_word = 16'hFFFF;
      2: k_word = 16'h0001;
      3: k_word = 16'h8000;
      4: k_word = $urandom_range(60000, 65535);
      default: k_word = $urandom;
    endcase
    no_idle = ($urandom_range(0, 4) == 0);
    set_filter(count_word, k_word);
    style = $urandom_range(0, 4);
    s = $urandom;
    delta = $urandom_range(0, 2000) - 1000;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        s = $urandom;
      end else begin
        case (style)
          0: s = $urandom;
          1: if ($urandom_range(0, 15) == 0) s = $urandom;
          2: s = $urandom_range(0, 64) - 32;
          3: s = $urandom_range(0, 1) ? 16'sh7FFF - $urandom_range(0, 3)
                                      : 16'sh8000 + $urandom_range(0, 3);
          default: s = s + delta;
        endcase
      end
      sample_queue.push_back(s);
    end
    drain();
  endtask

  initial begin
    int random_total;
    int n;
    for (int i = 0; i < NUM_STAGES; i++) stage_mem[i] = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: one stage with k of zero copies the sample through.
    sample_queue.push_back(16'sh7FFF);
    sample_queue.push_back(16'sh8000);
    sample_queue.push_back(16'sh0000);
    drain();

    // Bypass leaves every stage untouched.
    set_filter(16'd0, 16'd12345);
    sample_queue.push_back(16'sh8000);
    sample_queue.push_back(16'sh7FFF);
    sample_queue.push_back(-16'sd1);
    sample_queue.push_back(16'sd1);
    drain();

    // Full depth with the heaviest weight on the old values.
    set_filter(16'd32, 16'hFFFF);
    sample_queue.push_back(16'sh7FFF);
    sample_queue.push_back(16'sh7FFF);
    sample_queue.push_back(16'sh8000);
    drain();

    // A count above the stage limit, with every upper data bit set, acts as full depth.
    set_filter(16'hFFFF, 16'd40000);
    sample_queue.push_back(16'sh8000);
    sample_queue.push_back(16'sd12345);
    sample_queue.push_back(-16'sd1);
    drain();

    // Tiny k on negative differences exercises the floor of the product.
    set_filter(16'd3, 16'd3);
    sample_queue.push_back(-16'sd1);
    sample_queue.push_back(-16'sd3);
    sample_queue.push_back(16'sd5);
    drain();

    // Stages past the active count must still hold their earlier values.
    set_filter(16'd8, 16'd30000);
    sample_queue.push_back(16'sd1000);
    sample_queue.push_back(-16'sd1000);
    drain();
    set_filter(16'd32, 16'd30000);
    sample_queue.push_back(16'sd0);
    sample_queue.push_back(16'sh7FFF);
    drain();

    set_filter(16'd1, 16'h8000);
    sample_queue.push_back(-16'sd32767);
    sample_queue.push_back(16'sh7FFF);
    drain();

    random_total = 0;
    while (random_total < RANDOM_ITEMS) begin
      n = $urandom_range(20, 60);
      random_phase(n);
      random_total += n;
    end

    repeat (20) @(posedge clk_i);
    if (expected_samples.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_samples.size());
      fail_count++;
    end
    $display("Ran %0d samples through %0d filter settings, %0d results checked.",
             items_accepted, phase_count, results_checked);
    $display("Of those, %0d were bypassed and %0d went through all %0d stages.",
             bypass_items, full_depth_items, NUM_STAGES);
    if (fail_count == 0) begin
      $display("cascaded_one_pole_lowpass_top: match");
    end else begin
      $display("cascaded_one_pole_lowpass_top: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/colp_pkg.sv
rtl/colp_ram.sv
rtl/cascaded_one_pole_lowpass_top.sv
tb/tb_top.sv
